// ----- rtl/core/rnmtf_pkg.sv -----
package rnmtf_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int NAME_BYTES    = 15;
   localparam int NAME_W        = 8 * NAME_BYTES;
   localparam int LOW_W         = 64;
   localparam int HIGH_W        = NAME_W - LOW_W;
   localparam int POS_W         = 4;
   localparam int POS_N         = 1 << POS_W;
   localparam int COUNT_W       = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef logic [NAME_W-1:0] name_type;

   typedef struct packed {
      logic              kind;
      logic [LOW_W-1:0]  name_low;
      logic [HIGH_W-1:0] name_high;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [LOW_W-1:0]   entry_low;
      logic [HIGH_W-1:0]  entry_high;
      logic               entry_valid;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   // clear every byte from the first zero byte on
   function automatic name_type normalize(input name_type raw);
      logic     ended;
      name_type res;
      ended = 1'b0;
      res   = '0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (raw[8*b +: 8] == 8'h00) begin
            ended = 1'b1;
         end
         if (!ended) begin
            res[8*b +: 8] = raw[8*b +: 8];
         end
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/recent_name_move_to_front_list_core.sv -----
// A request passes the request stage register, then the response register.
// Throughput: one request per cycle while rsp_ready holds; the cell row
// compares and shifts together, so the compare plus prefix-hit logic sets
// the clock budget. Reset: synchronous, active high; clears count, cell
// valid bits and both pipeline valid flags. Entry contents are not reset
// and are never seen until written.
module recent_name_move_to_front_list_core #(
   parameter int DEPTH = rnmtf_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rnmtf_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rnmtf_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   // positions the read port can reach
   localparam int RD_N  = (DEPTH < rnmtf_pkg::POS_N) ? DEPTH : rnmtf_pkg::POS_N;

   // ---------------------------------------------------------------
   // Request stage: name normalized on the way in
   // ---------------------------------------------------------------
   logic                              st_valid_ff, st_valid_in;
   logic                              st_kind_ff, st_kind_in;
   rnmtf_pkg::name_type               st_name_ff, st_name_in;
   logic [rnmtf_pkg::POS_W-1:0]       st_pos_ff, st_pos_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   rnmtf_pkg::rsp_type                rsp_ff, rsp_in;

   logic [CNT_W-1:0]                  count_ff, count_in;

   logic                              exec;       // stage item executes this cycle
   logic                              exec_ins;
   logic                              take;

   assign exec      = st_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign exec_ins  = exec && (st_kind_ff == rnmtf_pkg::KIND_INSERT);
   assign req_ready = !st_valid_ff || exec;
   assign take      = req_valid && req_ready;

   always_comb begin
      st_valid_in = take ? 1'b1 : (exec ? 1'b0 : st_valid_ff);
      st_kind_in  = st_kind_ff;
      st_name_in  = st_name_ff;
      st_pos_in   = st_pos_ff;
      if (take) begin
         st_kind_in = req_payload.kind;
         st_name_in = rnmtf_pkg::normalize({req_payload.name_high, req_payload.name_low});
         st_pos_in  = req_payload.position;
      end
   end

   // ---------------------------------------------------------------
   // Cell row: cell 0 is most recent; each cell loads from its upper
   // neighbor while no hit sits above it. A miss therefore shifts the
   // whole row, carrying a valid bit in at the front.
   // ---------------------------------------------------------------
   rnmtf_pkg::name_type cell_name  [DEPTH];
   logic [DEPTH-1:0]    cell_valid;
   logic [DEPTH-1:0]    cell_match;
   logic [DEPTH-1:0]    cell_shift;
   logic                hit;

   assign hit = |cell_match;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rnmtf_pkg::name_type prev_name;
      logic                prev_valid;
      logic                hit_above;

      assign hit_above = |(cell_match & ((DEPTH'(1) << i) - DEPTH'(1)));
      assign cell_shift[i] = exec_ins && !hit_above;

      if (i == 0) begin : g_head
         assign prev_name  = st_name_ff;
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_name  = cell_name[i-1];
         assign prev_valid = cell_valid[i-1];
      end

      rnmtf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (cell_shift[i]),
         .prev_name   (prev_name),
         .prev_valid  (prev_valid),
         .probe_name  (st_name_ff),
         .entry       (cell_name[i]),
         .entry_valid (cell_valid[i]),
         .match       (cell_match[i])
      );
   end

   // ---------------------------------------------------------------
   // Count: grows on a miss until the row is full
   // ---------------------------------------------------------------
   always_comb begin
      count_in = count_ff;
      if (exec_ins && !hit && (count_ff != CNT_W'(DEPTH))) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------
   // Read port: valid bit of a cell equals position < count
   // ---------------------------------------------------------------
   rnmtf_pkg::name_type rd_name;
   logic                rd_valid;

   always_comb begin
      rd_name  = '0;
      rd_valid = 1'b0;
      for (int i = 0; i < RD_N; i++) begin
         if ((rnmtf_pkg::POS_W'(i) == st_pos_ff) && cell_valid[i]) begin
            rd_name  = cell_name[i];
            rd_valid = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response register: holds a finished response while the next
   // request waits in the stage
   // ---------------------------------------------------------------
   logic [CNT_W+rnmtf_pkg::COUNT_W-1:0] count_ext;

   assign count_ext = (CNT_W + rnmtf_pkg::COUNT_W)'(count_in);

   always_comb begin
      rsp_valid_in = exec ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);
      rsp_in       = rsp_ff;
      if (exec) begin
         rsp_in.count = count_ext[rnmtf_pkg::COUNT_W-1:0];
         if (st_kind_ff == rnmtf_pkg::KIND_INSERT) begin
            rsp_in.entry_low   = '0;
            rsp_in.entry_high  = '0;
            rsp_in.entry_valid = hit;
         end else begin
            rsp_in.entry_low   = rd_name[rnmtf_pkg::LOW_W-1:0];
            rsp_in.entry_high  = rd_name[rnmtf_pkg::NAME_W-1:rnmtf_pkg::LOW_W];
            rsp_in.entry_valid = rd_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_kind_ff <= st_kind_in;
      st_name_ff <= st_name_in;
      st_pos_ff  <= st_pos_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         st_valid_ff  <= st_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/core/rnmtf_cell.sv -----
module rnmtf_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  rnmtf_pkg::name_type prev_name,
   input  logic                prev_valid,
   input  rnmtf_pkg::name_type probe_name,
   output rnmtf_pkg::name_type entry,
   output logic                entry_valid,
   output logic                match
);

   rnmtf_pkg::name_type entry_ff, entry_in;
   logic                valid_ff, valid_in;

   always_comb begin
      entry_in = shift ? prev_name  : entry_ff;
      valid_in = shift ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry       = entry_ff;
   assign entry_valid = valid_ff;
   assign match       = valid_ff && (entry_ff == probe_name);

endmodule
